### hdl/ola_pkg.sv
// Shared types, constants and helpers for the ordered list block.
`timescale 1ns / 1ps

package ola_pkg;

  localparam int LIST_DEPTH = 16;
  localparam int IDX_W      = $clog2(LIST_DEPTH);
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
  localparam int DATA_W     = 32;

  localparam logic [1:0] CMD_APPEND = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_LIST   = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] value;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [CNT_W-1:0]   count;
    logic [CNT_W-1:0]   position;
    logic signed [31:0] element;
    logic               last;
  } out_t;

  typedef struct packed {
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [DATA_W-1:0] wr_data;
  } mem_req_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_SHIFT,
    S_LIST,
    S_RESP
  } state_t;

  function automatic out_t make_resp(input logic [1:0] status, input logic [CNT_W-1:0] count);
    out_t r;
    r.status   = status;
    r.count    = count;
    r.position = '0;
    r.element  = '0;
    r.last     = 1'b1;
    return r;
  endfunction

endpackage

### hdl/ordered_list_append_delete.sv
// Top level of the bounded ordered list: entry RAM plus command sequencer.
`timescale 1ns / 1ps

//  channel | direction | handshake        | beat
//  --------+-----------+------------------+--------------------------------------
//  in_     | input     | in_valid/in_stall | command, value
//  out_    | output    | out_valid/out_stall | status, count, position, element, last
//
//  One command at a time; in_stall is high from acceptance until the command's
//  last beat has been loaded into the output register. A delete runs a search
//  up to the first equal entry, then a shift of the entries behind it, one RAM
//  read a cycle; delete or list on an empty list and append when full answer
//  with a single status beat. Reset clears the count and the control state;
//  the entries themselves are not cleared. out_stall holds the current beat
//  and pauses the listing without losing entries.

module ordered_list_append_delete (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  ola_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output ola_pkg::out_t out_data
);

  ola_pkg::mem_req_t           mem_req;
  logic [ola_pkg::DATA_W-1:0]  rd_data;

  // entries live in RAM; the sequencer reads, shifts and writes them back
  ola_ram #(
    .DEPTH (ola_pkg::LIST_DEPTH),
    .WIDTH (ola_pkg::DATA_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_req.wr_en),
    .wr_addr (mem_req.wr_addr),
    .wr_data (mem_req.wr_data),
    .rd_en   (mem_req.rd_en),
    .rd_addr (mem_req.rd_addr),
    .rd_data (rd_data)
  );

  ola_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .mem_req   (mem_req),
    .rd_data   (rd_data)
  );

endmodule

### hdl/ola_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
`timescale 1ns / 1ps

module ola_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // hold read data until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### hdl/ola_ctrl.sv
// Command sequencer: search, shift and listing over the entry RAM, plus the output register.
`timescale 1ns / 1ps

module ola_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  ola_pkg::in_t              in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output ola_pkg::out_t             out_data,
  output ola_pkg::mem_req_t         mem_req,
  input  logic [ola_pkg::DATA_W-1:0] rd_data
);

  ola_pkg::state_t                 state_r, state_nxt;
  logic [ola_pkg::CNT_W-1:0]       len_r, len_nxt;
  logic [ola_pkg::DATA_W-1:0]      val_r, val_nxt;
  logic [ola_pkg::CNT_W-1:0]       iss_r, iss_nxt;
  logic                            pend_r, pend_nxt;
  logic [ola_pkg::IDX_W-1:0]       rd_idx_r, rd_idx_nxt;
  ola_pkg::out_t                   resp_r, resp_nxt;
  logic                            out_valid_r, out_valid_nxt;
  ola_pkg::out_t                   out_data_r, out_data_nxt;

  logic                            out_free;
  logic                            issue;
  logic                            at_last;
  logic [ola_pkg::CNT_W-1:0]       last_idx;
  logic [ola_pkg::CNT_W-1:0]       rd_idx_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ola_pkg::S_IDLE;
      len_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r      <= val_nxt;
    iss_r      <= iss_nxt;
    rd_idx_r   <= rd_idx_nxt;
    resp_r     <= resp_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_free   = !out_valid_r || !out_stall;
  assign last_idx   = len_r - ola_pkg::CNT_W'(1);
  assign rd_idx_ext = ola_pkg::CNT_W'(rd_idx_r);
  assign at_last    = (rd_idx_ext == last_idx);

  always_comb begin
    state_nxt     = state_r;
    len_nxt       = len_r;
    val_nxt       = val_r;
    iss_nxt       = iss_r;
    pend_nxt      = pend_r;
    rd_idx_nxt    = rd_idx_r;
    resp_nxt      = resp_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    mem_req       = '0;
    issue         = 1'b0;

    case (state_r)
      ola_pkg::S_IDLE: begin
        if (in_valid) begin
          val_nxt  = in_data.value;
          iss_nxt  = '0;
          pend_nxt = 1'b0;
          case (in_data.command)
            ola_pkg::CMD_APPEND: begin
              if (len_r == ola_pkg::CNT_W'(ola_pkg::LIST_DEPTH)) begin
                resp_nxt = ola_pkg::make_resp(ola_pkg::ST_FULL, len_r);
              end else begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = len_r[ola_pkg::IDX_W-1:0];
                mem_req.wr_data = in_data.value;
                len_nxt         = len_r + ola_pkg::CNT_W'(1);
                resp_nxt        = ola_pkg::make_resp(ola_pkg::ST_OK, len_nxt);
              end
              state_nxt = ola_pkg::S_RESP;
            end
            ola_pkg::CMD_DELETE: begin
              if (len_r == '0) begin
                resp_nxt  = ola_pkg::make_resp(ola_pkg::ST_EMPTY, len_r);
                state_nxt = ola_pkg::S_RESP;
              end else begin
                state_nxt = ola_pkg::S_SEARCH;
              end
            end
            ola_pkg::CMD_LIST: begin
              if (len_r == '0) begin
                resp_nxt  = ola_pkg::make_resp(ola_pkg::ST_EMPTY, len_r);
                state_nxt = ola_pkg::S_RESP;
              end else begin
                state_nxt = ola_pkg::S_LIST;
              end
            end
            default: begin
              // unused code: drop it
              state_nxt = ola_pkg::S_IDLE;
            end
          endcase
        end
      end

      ola_pkg::S_SEARCH: begin
        issue    = (iss_r < len_r);
        pend_nxt = issue;
        if (pend_r) begin
          if (rd_data == val_r) begin
            if (at_last) begin
              len_nxt   = last_idx;
              resp_nxt  = ola_pkg::make_resp(ola_pkg::ST_OK, last_idx);
              state_nxt = ola_pkg::S_RESP;
            end else begin
              state_nxt = ola_pkg::S_SHIFT;
            end
          end else if (at_last) begin
            resp_nxt  = ola_pkg::make_resp(ola_pkg::ST_NOT_FOUND, len_r);
            state_nxt = ola_pkg::S_RESP;
          end
        end
      end

      ola_pkg::S_SHIFT: begin
        issue    = (iss_r < len_r);
        pend_nxt = issue;
        if (pend_r) begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = rd_idx_r - ola_pkg::IDX_W'(1);
          mem_req.wr_data = rd_data;
          if (at_last) begin
            len_nxt   = last_idx;
            resp_nxt  = ola_pkg::make_resp(ola_pkg::ST_OK, last_idx);
            state_nxt = ola_pkg::S_RESP;
          end
        end
      end

      ola_pkg::S_LIST: begin
        issue = (iss_r < len_r) && (!pend_r || out_free);
        if (pend_r && out_free) begin
          out_valid_nxt         = 1'b1;
          out_data_nxt.status   = ola_pkg::ST_OK;
          out_data_nxt.count    = len_r;
          out_data_nxt.position = rd_idx_ext + ola_pkg::CNT_W'(1);
          out_data_nxt.element  = rd_data;
          out_data_nxt.last     = at_last;
          pend_nxt              = 1'b0;
          if (at_last) begin
            state_nxt = ola_pkg::S_IDLE;
          end
        end
        if (issue) begin
          pend_nxt = 1'b1;
        end
      end

      ola_pkg::S_RESP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = resp_r;
          state_nxt     = ola_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = ola_pkg::S_IDLE;
      end
    endcase

    if (issue) begin
      mem_req.rd_en   = 1'b1;
      mem_req.rd_addr = iss_r[ola_pkg::IDX_W-1:0];
      iss_nxt         = iss_r + ola_pkg::CNT_W'(1);
      rd_idx_nxt      = iss_r[ola_pkg::IDX_W-1:0];
    end

    // a match leaves the search: start the shift at the entry after it
    if (state_r == ola_pkg::S_SEARCH && state_nxt == ola_pkg::S_SHIFT) begin
      iss_nxt  = rd_idx_ext + ola_pkg::CNT_W'(1);
      pend_nxt = 1'b0;
    end
  end

  assign in_stall  = (state_r != ola_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### hdl/ola_checker.sv
// Port-level checks for the ordered list block, bound to its top level.
`timescale 1ns / 1ps

module ola_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          out_valid,
  input logic          out_stall,
  input ola_pkg::out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output beat changed");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.count <= ola_pkg::CNT_W'(ola_pkg::LIST_DEPTH))
    else $error("count beyond list depth");

  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ola_pkg::ST_OK |->
      out_data.last && out_data.position == '0 && out_data.element == '0)
    else $error("error beat not a lone final beat");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ola_pkg::ST_EMPTY |-> out_data.count == '0)
    else $error("empty status with nonzero count");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.position != '0 |-> out_data.position <= out_data.count)
    else $error("list position beyond count");

endmodule

bind ordered_list_append_delete ola_checker u_ola_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

### tb/ordered_list_append_delete_tb.sv
// Self-checking testbench for the ordered list block: paced driver, stalling sink, checker.
`timescale 1ns / 1ps

module ordered_list_append_delete_tb;

  // Generous cycle budget: worst case is every command listing a full list
  // against a heavily stalling sink, plus sender gaps and the long hold-off.
  localparam int LIMIT_CYCLES  = 400000;
  localparam int TOTAL_ITEMS   = 480;
  localparam int HOLD_CYCLES   = 600;
  localparam int HOLD_TRIGGER  = 150;
  localparam int SETTLE_CYCLES = 60;
  localparam int MAX_PRINTED   = 40;

  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // One planned input beat; drain asks the sender to wait for every
  // outstanding result before it offers this beat.
  typedef struct {
    ola_pkg::in_t beat;
    bit           drain;
  } plan_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  ola_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  ola_pkg::out_t out_data;

  plan_t              pending[$];
  ola_pkg::out_t      due_beats[$];
  logic signed [31:0] held_values[$];
  logic signed [31:0] plan_values[$];

  int errors = 0;
  int cycles = 0;
  int beats_seen = 0;

  ordered_list_append_delete i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #1 clk = ~clk;

  // Abort on a hung block.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("ordered_list_append_delete: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor: a shadow of the list, updated as each command beat is accepted.
  // ---------------------------------------------------------------------------

  // Single result for append, delete, or a list of an empty list.
  function automatic ola_pkg::out_t status_beat(logic [1:0] st, int held);
    ola_pkg::out_t r;
    r.status   = st;
    r.count    = ola_pkg::CNT_W'(held);
    r.position = '0;
    r.element  = '0;
    r.last     = 1'b1;
    return r;
  endfunction

  task automatic predict_beats(input ola_pkg::in_t cmd_beat);
    int            idx;
    ola_pkg::out_t r;
    idx = -1;
    case (cmd_beat.command)
      ola_pkg::CMD_APPEND: begin
        // Refuse once full; the list stays as it was.
        if (held_values.size() >= ola_pkg::LIST_DEPTH) begin
          due_beats.push_back(status_beat(ola_pkg::ST_FULL, held_values.size()));
        end else begin
          held_values.push_back(cmd_beat.value);
          due_beats.push_back(status_beat(ola_pkg::ST_OK, held_values.size()));
        end
      end
      ola_pkg::CMD_DELETE: begin
        if (held_values.size() == 0) begin
          due_beats.push_back(status_beat(ola_pkg::ST_EMPTY, 0));
        end else begin
          // Only the first equal entry goes; later duplicates stay in order.
          for (int i = 0; i < held_values.size(); i++) begin
            if (idx < 0 && held_values[i] == cmd_beat.value) idx = i;
          end
          if (idx < 0) begin
            due_beats.push_back(status_beat(ola_pkg::ST_NOT_FOUND, held_values.size()));
          end else begin
            held_values.delete(idx);
            due_beats.push_back(status_beat(ola_pkg::ST_OK, held_values.size()));
          end
        end
      end
      ola_pkg::CMD_LIST: begin
        if (held_values.size() == 0) begin
          due_beats.push_back(status_beat(ola_pkg::ST_EMPTY, 0));
        end else begin
          // One beat per entry, positions from 1, last on the tail entry.
          for (int i = 0; i < held_values.size(); i++) begin
            r.status   = ola_pkg::ST_OK;
            r.count    = ola_pkg::CNT_W'(held_values.size());
            r.position = ola_pkg::CNT_W'(i + 1);
            r.element  = held_values[i];
            r.last     = (i == held_values.size() - 1);
            due_beats.push_back(r);
          end
        end
      end
      default: ; // unused code: no change, no result
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus planning. plan_values tracks what the list will hold so that
  // deletes can be aimed at present or absent values.
  // ---------------------------------------------------------------------------

  task automatic add_beat(input logic [1:0] cmd, input logic signed [31:0] val,
                          input bit drain = 1'b0);
    plan_t p;
    int    idx;
    idx = -1;
    p.beat.command = cmd;
    p.beat.value   = val;
    p.drain        = drain;
    pending.push_back(p);
    if (cmd == ola_pkg::CMD_APPEND && plan_values.size() < ola_pkg::LIST_DEPTH) begin
      plan_values.push_back(val);
    end else if (cmd == ola_pkg::CMD_DELETE) begin
      for (int i = 0; i < plan_values.size(); i++) begin
        if (idx < 0 && plan_values[i] == val) idx = i;
      end
      if (idx >= 0) plan_values.delete(idx);
    end
  endtask

  // Bias towards a small pool and the extremes so that duplicates occur.
  function automatic logic signed [31:0] pick_value();
    logic signed [31:0] v;
    case ($urandom_range(0, 3))
      0: v = $signed($urandom_range(0, 4)) - 2;
      1: begin
        case ($urandom_range(0, 3))
          0: v = 32'sh8000_0000;
          1: v = 32'sh7fff_ffff;
          2: v = '0;
          default: v = -1;
        endcase
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic bit planned_holds(logic signed [31:0] v);
    bit hit;
    hit = 1'b0;
    foreach (plan_values[i]) if (plan_values[i] == v) hit = 1'b1;
    return hit;
  endfunction

  function automatic logic signed [31:0] absent_value();
    logic signed [31:0] v;
    v = pick_value();
    while (planned_holds(v)) v = $urandom;
    return v;
  endfunction

  task automatic delete_present(input bit drain = 1'b0);
    add_beat(ola_pkg::CMD_DELETE, plan_values[$urandom_range(0, plan_values.size() - 1)],
             drain);
  endtask

  task automatic fill_sequence(input bit drain);
    int n;
    n = ola_pkg::LIST_DEPTH - plan_values.size() + $urandom_range(0, 2);
    add_beat(ola_pkg::CMD_APPEND, pick_value(), drain);
    for (int i = 1; i < n; i++) add_beat(ola_pkg::CMD_APPEND, pick_value());
    add_beat(ola_pkg::CMD_LIST, $urandom);
  endtask

  task automatic empty_sequence(input bit drain);
    add_beat(ola_pkg::CMD_LIST, $urandom, drain);
    while (plan_values.size() != 0) begin
      if ($urandom_range(0, 4) == 0) add_beat(ola_pkg::CMD_DELETE, absent_value());
      else delete_present();
    end
    add_beat(ola_pkg::CMD_DELETE, pick_value());
    add_beat(ola_pkg::CMD_LIST, $urandom);
  endtask

  task automatic mixed_sequence(input bit drain);
    int n;
    n = $urandom_range(4, 12);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 5))
        0, 1: add_beat(ola_pkg::CMD_APPEND, pick_value(), drain && i == 0);
        2: begin
          if (plan_values.size() != 0) delete_present(drain && i == 0);
          else add_beat(ola_pkg::CMD_DELETE, pick_value(), drain && i == 0);
        end
        3: add_beat(ola_pkg::CMD_DELETE, absent_value(), drain && i == 0);
        4: add_beat(ola_pkg::CMD_LIST, $urandom, drain && i == 0);
        default: add_beat(CMD_UNUSED, $urandom, drain && i == 0);
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers the head of the pending queue in bursts with gaps, holds
  // the beat steady while stalled, and predicts each beat on acceptance.
  // ---------------------------------------------------------------------------
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) begin
        predict_beats(in_data);
        pending.delete(0);
      end
      if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending.size() == 0 || (pending[0].drain && due_beats.size() != 0)) begin
        // Hold back a drain beat until every outstanding result has come.
        in_valid <= 1'b0;
      end else begin
        in_valid <= 1'b1;
        in_data  <= pending[0].beat;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 12);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sink: stalls in modes of random length (none, light, heavy), plus one
  // long hold-off so that the block backs up and stalls its input.
  // ---------------------------------------------------------------------------
  int  stall_mode = 0;
  int  mode_left = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!hold_done && beats_seen >= HOLD_TRIGGER) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left  = $urandom_range(20, 200);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Checker: compare every accepted result beat with the oldest expectation.
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (errors < MAX_PRINTED) begin
      $display("[%0d] %s: got %0d, want %0d", cycles, what, got, want);
    end
    errors++;
  endtask

  ola_pkg::out_t want_beat;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      beats_seen <= beats_seen + 1;
      if (due_beats.size() == 0) begin
        report_mismatch("result with nothing due, status", out_data.status, -1);
      end else begin
        want_beat = due_beats.pop_front();
        if (out_data.status !== want_beat.status)
          report_mismatch("status", out_data.status, want_beat.status);
        if (out_data.count !== want_beat.count)
          report_mismatch("count", out_data.count, want_beat.count);
        if (out_data.position !== want_beat.position)
          report_mismatch("position", out_data.position, want_beat.position);
        if (out_data.element !== want_beat.element)
          report_mismatch("element", out_data.element, want_beat.element);
        if (out_data.last !== want_beat.last)
          report_mismatch("last", out_data.last, want_beat.last);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Plan the run, release reset, then wait for the block to drain.
  // ---------------------------------------------------------------------------
  initial begin
    // Directed: empty cases, extremes, duplicates, first/middle/last delete.
    add_beat(ola_pkg::CMD_LIST, $urandom);
    add_beat(ola_pkg::CMD_DELETE, 32'sd7);
    add_beat(ola_pkg::CMD_APPEND, 32'sh8000_0000);
    add_beat(ola_pkg::CMD_APPEND, 32'sh7fff_ffff);
    add_beat(ola_pkg::CMD_APPEND, 32'sd0);
    add_beat(ola_pkg::CMD_APPEND, 32'sd5);
    add_beat(ola_pkg::CMD_APPEND, 32'sd5);
    add_beat(ola_pkg::CMD_APPEND, -32'sd1);
    add_beat(ola_pkg::CMD_LIST, 32'hffff_ffff);
    add_beat(ola_pkg::CMD_DELETE, 32'sd12345);
    add_beat(ola_pkg::CMD_DELETE, 32'sd0);
    add_beat(ola_pkg::CMD_DELETE, 32'sh8000_0000);
    add_beat(ola_pkg::CMD_DELETE, -32'sd1);
    add_beat(ola_pkg::CMD_DELETE, 32'sd5);
    add_beat(CMD_UNUSED, 32'hffff_ffff);
    add_beat(CMD_UNUSED, 32'h0000_0000);
    add_beat(ola_pkg::CMD_LIST, $urandom);
    add_beat(ola_pkg::CMD_APPEND, 32'sd9, 1'b1);

    // Random: start with a fill so the full case is reached early, then mix.
    fill_sequence(1'b0);
    add_beat(ola_pkg::CMD_APPEND, pick_value());
    while (pending.size() < TOTAL_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2: fill_sequence($urandom_range(0, 7) == 0);
        3, 4:    empty_sequence($urandom_range(0, 7) == 0);
        5, 6, 7: mixed_sequence($urandom_range(0, 7) == 0);
        8: begin
          // Noise: unused codes, ignored by the block.
          repeat ($urandom_range(1, 3)) add_beat(CMD_UNUSED, $urandom);
        end
        default: add_beat(ola_pkg::CMD_LIST, $urandom);
      endcase
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (pending.size() != 0 || in_valid) @(posedge clk);
    while (due_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("ordered_list_append_delete: match");
    end else begin
      $display("ordered_list_append_delete: mismatch");
    end
    $finish;
  end

endmodule
